>>> hw/rtl/ctcs_pkg.sv
// ---------------------------------------------------------------------------
// ctcs_pkg
// Shared types and constants of the comparator trim calibration sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package ctcs_pkg;

    // sweep limits
    localparam logic [3:0] MAX_UP_OFFSET   = 4'd7;
    localparam logic [3:0] MAX_DOWN_OFFSET = 4'd8;

    // fixed bus addresses
    localparam logic [15:0] SEL_ADDR    = 16'h1020;
    localparam logic [15:0] STATUS_ADDR = 16'h1029;

    // configuration register indexes
    localparam logic [2:0] CFG_VOLTAGE_SELECT  = 3'd0;
    localparam logic [2:0] CFG_TRIM_ADDRESS    = 3'd1;
    localparam logic [2:0] CFG_DEFAULT_TRIM    = 3'd2;
    localparam logic [2:0] CFG_RESULT_BIT      = 3'd3;
    localparam logic [2:0] CFG_TRIM_NIBBLE     = 3'd4;
    localparam logic [2:0] CFG_DAC_INITIAL     = 3'd5;
    localparam logic [2:0] CFG_DAC_LOWER       = 3'd6;
    localparam logic [2:0] CFG_DAC_HIGHER      = 3'd7;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_CAL  = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        STEP_DAC        = 3'd0,
        STEP_SEL_WRITE  = 3'd1,
        STEP_DEF_TRIM   = 3'd2,
        STEP_FIRST_READ = 3'd3,
        STEP_TRIM_WRITE = 3'd4,
        STEP_CMP_READ   = 3'd5,
        STEP_SAVE_READ  = 3'd6
    } step_t;

    typedef enum logic [2:0] {
        RQ_NONE = 3'd0,
        RQ_DAC  = 3'd1,
        RQ_MEMW = 3'd2,
        RQ_PHYW = 3'd3,
        RQ_MEMR = 3'd4,
        RQ_PHYR = 3'd5
    } req_kind_t;

    typedef enum logic [1:0] {
        RT_NONE   = 2'd0,
        RT_LOWER  = 2'd1,
        RT_HIGHER = 2'd2
    } retest_t;

    typedef struct packed {
        logic [7:0]  voltage_select;
        logic [15:0] trim_register_address;
        logic [15:0] default_trim_word;
        logic [2:0]  result_bit_index;
        logic [1:0]  trim_nibble_index;
        logic [23:0] dac_initial_words;
        logic [15:0] dac_lower_retest_words;
        logic [15:0] dac_higher_retest_words;
    } cfg_t;

    typedef struct packed {
        req_kind_t   kind;
        logic [15:0] address;
        logic [23:0] data;
        phase_t      phase;
        logic        failed;
        logic        direction;
        logic [3:0]  offset;
        logic [15:0] saved_word;
    } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/ctcs_cfg.sv
// ---------------------------------------------------------------------------
// ctcs_cfg
// Configuration register file of the calibration sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module ctcs_cfg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_en,
    input  wire logic [2:0]   wr_index,
    input  wire logic [23:0]  wr_data,
    output ctcs_pkg::cfg_t    cfg,
    output logic              dac_load
);
    import ctcs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_VOLTAGE_SELECT: cfg_next.voltage_select          = wr_data[7:0];
                CFG_TRIM_ADDRESS:   cfg_next.trim_register_address   = wr_data[15:0];
                CFG_DEFAULT_TRIM:   cfg_next.default_trim_word       = wr_data[15:0];
                CFG_RESULT_BIT:     cfg_next.result_bit_index        = wr_data[2:0];
                CFG_TRIM_NIBBLE:    cfg_next.trim_nibble_index       = wr_data[1:0];
                CFG_DAC_INITIAL:    cfg_next.dac_initial_words       = wr_data;
                CFG_DAC_LOWER:      cfg_next.dac_lower_retest_words  = wr_data[15:0];
                CFG_DAC_HIGHER:     cfg_next.dac_higher_retest_words = wr_data[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg      = cfg_reg;
    assign dac_load = wr_en && (wr_index == CFG_DAC_INITIAL);

endmodule

`default_nettype wire

>>> hw/rtl/ctcs_core.sv
// ---------------------------------------------------------------------------
// ctcs_core
// Sequencer state and per-step logic: picks the bus request from the state
// and folds the bus outcome into the next state.
// ---------------------------------------------------------------------------
`default_nettype none

module ctcs_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ctcs_pkg::cfg_t cfg,
    input  wire logic           dac_load,
    input  wire logic [15:0]    dac_load_words,
    input  wire logic           accept,
    input  wire logic           bus_passed,
    input  wire logic [7:0]     read_low_byte,
    input  wire logic [7:0]     read_high_byte,
    output ctcs_pkg::result_t   result
);
    import ctcs_pkg::*;

    phase_t      phase_reg,  phase_next;
    step_t       step_reg,   step_next;
    logic        dir_reg,    dir_next;
    logic [3:0]  offset_reg, offset_next;
    retest_t     retest_reg, retest_next;
    logic [15:0] dac_reg,    dac_next;
    logic        fail_reg,   fail_next;
    logic [15:0] saved_reg,  saved_next;

    req_kind_t   kind;
    logic [15:0] address;
    logic [23:0] data;

    logic        cmp;
    logic [3:0]  limit;
    logic        trim_bad;
    logic [7:0]  delta;
    logic [7:0]  trim_lo;
    logic [7:0]  trim_hi;
    logic [15:0] trim_word;

    assign cmp   = read_low_byte[cfg.result_bit_index];
    assign limit = dir_reg ? MAX_DOWN_OFFSET : MAX_UP_OFFSET;

    // offset lands on the low or high nibble of the chosen byte
    always_comb
    begin
        trim_bad = offset_reg > limit;
        delta    = cfg.trim_nibble_index[0] ? {offset_reg, 4'd0} : {4'd0, offset_reg};
        trim_lo  = cfg.default_trim_word[7:0];
        trim_hi  = cfg.default_trim_word[15:8];
        if (!cfg.trim_nibble_index[1])
        begin
            trim_lo = dir_reg ? (trim_lo - delta) : (trim_lo + delta);
        end
        else
        begin
            trim_hi = dir_reg ? (trim_hi - delta) : (trim_hi + delta);
        end
        trim_word = trim_bad ? 16'd0 : {trim_hi, trim_lo};
    end

    // request issued by the current state
    always_comb
    begin
        kind    = RQ_NONE;
        address = 16'd0;
        data    = 24'd0;
        unique case (phase_reg)
            PH_WAIT:
            begin
                kind = RQ_DAC;
                data = {dac_reg, cfg.dac_initial_words[7:0]};
            end
            PH_CAL:
            begin
                unique case (step_reg)
                    STEP_DAC:
                    begin
                        kind = RQ_DAC;
                        data = {dac_reg, cfg.dac_initial_words[7:0]};
                    end
                    STEP_SEL_WRITE:
                    begin
                        kind    = RQ_MEMW;
                        address = SEL_ADDR;
                        data    = {16'd0, cfg.voltage_select};
                    end
                    STEP_DEF_TRIM:
                    begin
                        kind    = RQ_PHYW;
                        address = cfg.trim_register_address;
                        data    = {8'd0, cfg.default_trim_word};
                    end
                    STEP_FIRST_READ, STEP_CMP_READ:
                    begin
                        kind    = RQ_MEMR;
                        address = STATUS_ADDR;
                    end
                    STEP_TRIM_WRITE:
                    begin
                        kind    = RQ_PHYW;
                        address = cfg.trim_register_address;
                        data    = {8'd0, trim_word};
                    end
                    STEP_SAVE_READ:
                    begin
                        kind    = RQ_PHYR;
                        address = cfg.trim_register_address;
                    end
                    default:
                    begin
                        kind = RQ_NONE;
                    end
                endcase
            end
            default:
            begin
                kind = RQ_NONE;
            end
        endcase
    end

    // next state from the bus outcome
    always_comb
    begin
        phase_next  = phase_reg;
        step_next   = step_reg;
        dir_next    = dir_reg;
        offset_next = offset_reg;
        retest_next = retest_reg;
        dac_next    = dac_reg;
        fail_next   = fail_reg;
        saved_next  = saved_reg;
        unique case (phase_reg)
            PH_WAIT:
            begin
                step_next  = STEP_DAC;
                phase_next = PH_CAL;
            end
            PH_CAL:
            begin
                unique case (step_reg)
                    STEP_DAC:
                    begin
                        step_next = STEP_SEL_WRITE;
                    end
                    STEP_SEL_WRITE:
                    begin
                        if (bus_passed)
                        begin
                            step_next = STEP_DEF_TRIM;
                        end
                    end
                    STEP_DEF_TRIM:
                    begin
                        dir_next    = 1'b0;
                        offset_next = 4'd0;
                        if (bus_passed)
                        begin
                            step_next = STEP_FIRST_READ;
                        end
                    end
                    STEP_FIRST_READ:
                    begin
                        if (bus_passed)
                        begin
                            dir_next    = !cmp;
                            offset_next = 4'd1;
                            step_next   = STEP_TRIM_WRITE;
                        end
                    end
                    STEP_TRIM_WRITE:
                    begin
                        if (trim_bad)
                        begin
                            fail_next = 1'b1;
                        end
                        if (bus_passed)
                        begin
                            step_next = STEP_CMP_READ;
                        end
                    end
                    STEP_CMP_READ:
                    begin
                        if (bus_passed)
                        begin
                            // comparator not flipped yet: keep sweeping, else retest once or fail
                            if (cmp != dir_reg)
                            begin
                                if (offset_reg < limit)
                                begin
                                    offset_next = offset_reg + 4'd1;
                                    step_next   = STEP_TRIM_WRITE;
                                end
                                else if (offset_reg == limit && retest_reg == RT_NONE)
                                begin
                                    if (!dir_reg)
                                    begin
                                        retest_next = RT_LOWER;
                                        dac_next    = cfg.dac_lower_retest_words;
                                    end
                                    else
                                    begin
                                        retest_next = RT_HIGHER;
                                        dac_next    = cfg.dac_higher_retest_words;
                                    end
                                    step_next = STEP_DAC;
                                end
                                else
                                begin
                                    fail_next = 1'b1;
                                end
                            end
                            else if (offset_reg <= limit)
                            begin
                                step_next = STEP_SAVE_READ;
                            end
                            else
                            begin
                                fail_next = 1'b1;
                            end
                        end
                    end
                    STEP_SAVE_READ:
                    begin
                        if (bus_passed)
                        begin
                            saved_next = {read_high_byte, read_low_byte};
                            phase_next = PH_DONE;
                            step_next  = STEP_DAC;
                        end
                    end
                    default:
                    begin
                        step_next = step_reg;
                    end
                endcase
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT;
            step_reg   <= STEP_DAC;
            dir_reg    <= 1'b0;
            offset_reg <= 4'd0;
            retest_reg <= RT_NONE;
            dac_reg    <= 16'd0;
            fail_reg   <= 1'b0;
            saved_reg  <= 16'd0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg  <= phase_next;
                step_reg   <= step_next;
                dir_reg    <= dir_next;
                offset_reg <= offset_next;
                retest_reg <= retest_next;
                fail_reg   <= fail_next;
                saved_reg  <= saved_next;
            end
            // a dac table write reloads the active words
            if (dac_load)
            begin
                dac_reg <= dac_load_words;
            end
            else if (accept)
            begin
                dac_reg <= dac_next;
            end
        end
    end

    always_comb
    begin
        result.kind       = kind;
        result.address    = address;
        result.data       = data;
        result.phase      = phase_next;
        result.failed     = fail_next;
        result.direction  = dir_next;
        result.offset     = offset_next;
        result.saved_word = saved_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/comparator_trim_calibration_sequencer_unit.sv
// ---------------------------------------------------------------------------
// comparator_trim_calibration_sequencer_unit
// Step sequencer that trims a comparator offset through bus requests.
// ---------------------------------------------------------------------------
// Usage:
// - step channel (step_valid/step_ready): one beat per sequencer step, with
//   the pass flag and read bytes of the bus transaction of that step.
// - result channel (result_valid/result_ready): one beat per step beat, with
//   the request issued in that step and the state after the step.
// - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): register writes,
//   always ready; write only while no step is in flight.
// A step accepted at an edge shows its result beat right after that edge.
// Throughput is one step per cycle while the receiver does not stall; the
// state update is a single pass of logic into the state registers and one
// result register.
// When the receiver stalls, the result register holds its beat and
// step_ready stays high only if that beat is taken in the same cycle.
// Reset clears all registers; the sequencer starts in the waiting phase.
// ---------------------------------------------------------------------------
`default_nettype none

module comparator_trim_calibration_sequencer_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step_valid,
    output logic              step_ready,
    input  wire logic         bus_passed,
    input  wire logic [7:0]   read_low_byte,
    input  wire logic [7:0]   read_high_byte,
    output logic              result_valid,
    input  wire logic         result_ready,
    output logic [2:0]        request_kind,
    output logic [15:0]       request_address,
    output logic [23:0]       request_data,
    output logic [1:0]        phase,
    output logic              failed,
    output logic              sweep_direction,
    output logic [3:0]        current_offset,
    output logic [15:0]       saved_trim_word,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [23:0]  cfg_data
);
    import ctcs_pkg::*;

    cfg_t        cfg;
    logic        dac_load;
    logic        accept;
    result_t     step_result;
    result_t     result_reg;
    logic        valid_reg;
    logic        valid_next;

    assign cfg_ready  = 1'b1;
    assign step_ready = !valid_reg || result_ready;
    assign accept     = step_valid && step_ready;

    ctcs_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg),
        .dac_load (dac_load)
    );

    ctcs_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .dac_load       (dac_load),
        .dac_load_words (cfg_data[23:8]),
        .accept         (accept),
        .bus_passed     (bus_passed),
        .read_low_byte  (read_low_byte),
        .read_high_byte (read_high_byte),
        .result         (step_result)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result beat payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_reg <= '0;
        end
        else if (accept)
        begin
            result_reg <= step_result;
        end
    end

    assign result_valid    = valid_reg;
    assign request_kind    = result_reg.kind;
    assign request_address = result_reg.address;
    assign request_data    = result_reg.data;
    assign phase           = result_reg.phase;
    assign failed          = result_reg.failed;
    assign sweep_direction = result_reg.direction;
    assign current_offset  = result_reg.offset;
    assign saved_trim_word = result_reg.saved_word;

`ifndef SYNTH
    a_accept_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> result_valid
    ) else $error("step beat accepted without a result beat");

    a_offset_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> (current_offset <= MAX_DOWN_OFFSET)
    ) else $error("trim offset beyond sweep range");

    a_phase_code: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> (phase != 2'd3)
    ) else $error("unused phase code in result");

    a_dac_no_address: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && request_kind == RQ_DAC) |-> (request_address == 16'd0)
    ) else $error("dac request carries a bus address");
`endif

endmodule

`default_nettype wire

>>> verif/tb_comparator_trim_calibration_sequencer_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_comparator_trim_calibration_sequencer_unit
// Self-checking bench for the comparator trim calibration sequencer.
// Step beats carry random bus outcomes and read bytes. The status bytes are
// steered so that the run walks the offset sweep, takes the one retest, runs
// into the sticky fail, and at the end flips the comparator to save the
// trimmed word. Every result beat is checked field by field against a
// behavioral copy of the sequencer kept in the bench. Register settings
// change between bursts of steps, and only while the unit is idle.
// ---------------------------------------------------------------------------
module tb_comparator_trim_calibration_sequencer_unit;
    import ctcs_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_STEPS = 470;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        step_valid = 1'b0;
    logic        step_ready;
    logic        bus_passed = 1'b0;
    logic [7:0]  read_low_byte = '0;
    logic [7:0]  read_high_byte = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [2:0]  request_kind;
    logic [15:0] request_address;
    logic [23:0] request_data;
    logic [1:0]  phase;
    logic        failed;
    logic        sweep_direction;
    logic [3:0]  current_offset;
    logic [15:0] saved_trim_word;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    // bench copy of the sequencer state and its registers
    cfg_t        regs;
    phase_t      seq_phase;
    logic [2:0]  seq_step;
    logic        seq_dir;
    logic [3:0]  seq_offset;
    logic [1:0]  seq_retest;
    logic [15:0] seq_dac;
    logic        seq_fail;
    logic [15:0] seq_saved;

    result_t     awaited_results[$];
    result_t     want;
    int          error_count = 0;
    int          quiet_cycles = 0;
    int          stall_left = 0;
    bit          jitter = 1'b1;

    comparator_trim_calibration_sequencer_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .step_valid      (step_valid),
        .step_ready      (step_ready),
        .bus_passed      (bus_passed),
        .read_low_byte   (read_low_byte),
        .read_high_byte  (read_high_byte),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .request_kind    (request_kind),
        .request_address (request_address),
        .request_data    (request_data),
        .phase           (phase),
        .failed          (failed),
        .sweep_direction (sweep_direction),
        .current_offset  (current_offset),
        .saved_trim_word (saved_trim_word),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] rand_byte();
        logic [31:0] raw;
        raw = $urandom;
        return raw[7:0];
    endfunction

    // random byte with the comparator output bit forced
    function automatic logic [7:0] status_byte(input logic level);
        logic [7:0] b;
        b = rand_byte();
        b[regs.result_bit_index] = level;
        return b;
    endfunction

    // mostly short, a few long
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (!jitter || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 9);
        return $urandom_range(15, 30);
    endfunction

    function automatic logic [3:0] sweep_limit();
        return seq_dir ? MAX_DOWN_OFFSET : MAX_UP_OFFSET;
    endfunction

    // one sequencer step: the request it issues and the state after it
    function automatic result_t advance_sequencer(input logic pass, input logic [7:0] lo,
                                                  input logic [7:0] hi);
        result_t    r;
        logic       cmp;
        logic [7:0] lo_b;
        logic [7:0] hi_b;
        logic [7:0] delta;
        r = '0;
        r.kind = RQ_NONE;
        cmp = lo[regs.result_bit_index];
        if (seq_phase == PH_WAIT)
        begin
            r.kind = RQ_DAC;
            r.data = {seq_dac, regs.dac_initial_words[7:0]};
            seq_step = STEP_DAC;
            seq_phase = PH_CAL;
        end
        else if (seq_phase == PH_CAL)
        begin
            case (seq_step)
                STEP_DAC:
                begin
                    r.kind = RQ_DAC;
                    r.data = {seq_dac, regs.dac_initial_words[7:0]};
                    seq_step = STEP_SEL_WRITE;
                end
                STEP_SEL_WRITE:
                begin
                    r.kind = RQ_MEMW;
                    r.address = SEL_ADDR;
                    r.data = {16'd0, regs.voltage_select};
                    if (pass)
                        seq_step = STEP_DEF_TRIM;
                end
                STEP_DEF_TRIM:
                begin
                    seq_dir = 1'b0;
                    seq_offset = 4'd0;
                    r.kind = RQ_PHYW;
                    r.address = regs.trim_register_address;
                    r.data = {8'd0, regs.default_trim_word};
                    if (pass)
                        seq_step = STEP_FIRST_READ;
                end
                STEP_FIRST_READ:
                begin
                    r.kind = RQ_MEMR;
                    r.address = STATUS_ADDR;
                    if (pass)
                    begin
                        seq_dir = !cmp;
                        seq_offset = 4'd1;
                        seq_step = STEP_TRIM_WRITE;
                    end
                end
                STEP_TRIM_WRITE:
                begin
                    r.kind = RQ_PHYW;
                    r.address = regs.trim_register_address;
                    lo_b = regs.default_trim_word[7:0];
                    hi_b = regs.default_trim_word[15:8];
                    delta = {4'd0, seq_offset} << (4 * regs.trim_nibble_index[0]);
                    if (seq_offset > sweep_limit())
                        seq_fail = 1'b1;
                    else
                    begin
                        // byte-wide, wraps modulo 256
                        if (!regs.trim_nibble_index[1])
                            lo_b = seq_dir ? lo_b - delta : lo_b + delta;
                        else
                            hi_b = seq_dir ? hi_b - delta : hi_b + delta;
                        r.data = {8'd0, hi_b, lo_b};
                    end
                    if (pass)
                        seq_step = STEP_CMP_READ;
                end
                STEP_CMP_READ:
                begin
                    r.kind = RQ_MEMR;
                    r.address = STATUS_ADDR;
                    if (pass)
                    begin
                        if (cmp == !seq_dir)
                        begin
                            // comparator has not flipped yet
                            if (seq_offset < sweep_limit())
                            begin
                                seq_offset = seq_offset + 4'd1;
                                seq_step = STEP_TRIM_WRITE;
                            end
                            else if (seq_offset == sweep_limit() && seq_retest == RT_NONE)
                            begin
                                seq_retest = seq_dir ? RT_HIGHER : RT_LOWER;
                                seq_dac = seq_dir ? regs.dac_higher_retest_words
                                                  : regs.dac_lower_retest_words;
                                seq_step = STEP_DAC;
                            end
                            else
                                seq_fail = 1'b1;
                        end
                        else if (seq_offset <= sweep_limit())
                            seq_step = STEP_SAVE_READ;
                        else
                            seq_fail = 1'b1;
                    end
                end
                STEP_SAVE_READ:
                begin
                    r.kind = RQ_PHYR;
                    r.address = regs.trim_register_address;
                    if (pass)
                    begin
                        seq_saved = {hi, lo};
                        seq_phase = PH_DONE;
                        seq_step = STEP_DAC;
                    end
                end
                default:
                begin
                end
            endcase
        end
        r.phase = seq_phase;
        r.failed = seq_fail;
        r.direction = seq_dir;
        r.offset = seq_offset;
        r.saved_word = seq_saved;
        return r;
    endfunction

    function automatic logic [23:0] register_value(input logic [2:0] idx);
        logic [23:0] full;
        logic [31:0] raw;
        case (idx)
            CFG_VOLTAGE_SELECT: full = 24'hFF;
            CFG_RESULT_BIT:     full = 24'h7;
            CFG_TRIM_NIBBLE:    full = 24'h3;
            CFG_DAC_INITIAL:    full = 24'hFFFFFF;
            default:            full = 24'hFFFF;
        endcase
        raw = $urandom;
        case (raw[1:0])
            2'd0:    return '0;
            2'd1:    return full;
            // bits above the register width are dropped by the unit
            default: return raw[31:8];
        endcase
    endfunction

    task automatic drive_step(input logic pass, input logic [7:0] lo, input logic [7:0] hi);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            step_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        step_valid <= 1'b1;
        bus_passed <= pass;
        read_low_byte <= lo;
        read_high_byte <= hi;
        do
            @(posedge clk);
        while (!step_ready);
        awaited_results.push_back(advance_sequencer(pass, lo, hi));
        @(negedge clk);
    endtask

    task automatic settle_idle();
        step_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // caller lowers cfg_valid after its last write
    task automatic write_register(input logic [2:0] idx, input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_VOLTAGE_SELECT: regs.voltage_select = value[7:0];
            CFG_TRIM_ADDRESS:   regs.trim_register_address = value[15:0];
            CFG_DEFAULT_TRIM:   regs.default_trim_word = value[15:0];
            CFG_RESULT_BIT:     regs.result_bit_index = value[2:0];
            CFG_TRIM_NIBBLE:    regs.trim_nibble_index = value[1:0];
            CFG_DAC_INITIAL:
            begin
                regs.dac_initial_words = value;
                seq_dac = value[23:8];
            end
            CFG_DAC_LOWER:      regs.dac_lower_retest_words = value[15:0];
            CFG_DAC_HIGHER:     regs.dac_higher_retest_words = value[15:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
    endtask

    task automatic rewrite_registers(input int count);
        logic [7:0] pick;
        settle_idle();
        repeat (count)
        begin
            pick = rand_byte();
            write_register(pick[2:0], register_value(pick[2:0]));
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_register_extremes();
        write_register(CFG_VOLTAGE_SELECT, 24'hFF);
        write_register(CFG_TRIM_ADDRESS, 24'hFFFF);
        write_register(CFG_DEFAULT_TRIM, 24'hFFFF);
        write_register(CFG_RESULT_BIT, 24'h7);
        write_register(CFG_TRIM_NIBBLE, 24'h3);
        write_register(CFG_DAC_INITIAL, 24'hFFFFFF);
        write_register(CFG_DAC_LOWER, 24'h0000);
        write_register(CFG_DAC_HIGHER, 24'hFFFF);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_startup_steps();
        logic [7:0] coin;
        coin = rand_byte();
        // dac writes go out whatever the bus reports
        drive_step(1'b0, 8'h00, 8'h00);
        drive_step(1'b0, 8'hFF, 8'hFF);
        // failed select write and default trim write are repeated
        drive_step(1'b0, rand_byte(), rand_byte());
        drive_step(1'b1, rand_byte(), rand_byte());
        drive_step(1'b0, rand_byte(), rand_byte());
        drive_step(1'b1, rand_byte(), rand_byte());
        // failed status read: the status byte is ignored
        drive_step(1'b0, status_byte(coin[0]), rand_byte());
        drive_step(1'b1, status_byte(coin[1]), rand_byte());
    endtask

    // sweep to the limit without a flip, into the retest
    task automatic test_first_sweep();
        int guard;
        guard = 0;
        while (seq_retest == RT_NONE && seq_phase != PH_DONE && guard < 40)
        begin
            // one failed trim write, then one failed read carrying a flipped status
            drive_step(guard != 0 && guard != 2, status_byte(guard == 2 ? seq_dir : !seq_dir),
                       rand_byte());
            guard++;
        end
    endtask

    task automatic test_random_steps(input int count);
        int         left_in_burst;
        logic       pass;
        logic [7:0] lo;
        logic [7:0] coin;
        left_in_burst = 0;
        repeat (count)
        begin
            if (left_in_burst == 0)
            begin
                coin = rand_byte();
                rewrite_registers(coin[1:0] + 1);
                jitter = coin[4:2] != 3'd0;
                // frequent register changes while sweeping, fewer once stuck
                left_in_burst = seq_fail ? $urandom_range(12, 40) : $urandom_range(2, 6);
            end
            coin = rand_byte();
            pass = coin < 8'd218;
            lo = rand_byte();
            // keep the comparator from flipping; failed reads carry any status
            if (seq_step == STEP_CMP_READ)
                lo = status_byte(pass ? !seq_dir : coin[0]);
            drive_step(pass, lo, rand_byte());
            left_in_burst--;
        end
    endtask

    task automatic test_trim_readback();
        int   guard;
        logic save_tried;
        guard = 0;
        save_tried = 1'b0;
        jitter = 1'b1;
        while (seq_phase != PH_DONE && guard < 60)
        begin
            if (seq_step == STEP_SAVE_READ)
            begin
                drive_step(save_tried, rand_byte(), rand_byte());
                save_tried = 1'b1;
            end
            else
                drive_step(1'b1, status_byte(seq_dir), rand_byte());
            guard++;
        end
        // done: no request, state frozen
        drive_step(1'b1, 8'hFF, 8'hFF);
        drive_step(1'b0, 8'h00, 8'h00);
        drive_step(1'b1, rand_byte(), rand_byte());
    endtask

    // receiver side stalls
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
            stall_left = gap_length();
        end
    end

    function automatic void check_field(input string field, input logic [23:0] expected,
                                        input logic [23:0] actual);
        if (actual !== expected)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, expected, actual);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result beat with no step outstanding, request_kind %0d", request_kind);
                error_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("request_kind", want.kind, request_kind);
                check_field("request_address", want.address, request_address);
                check_field("request_data", want.data, request_data);
                check_field("phase", want.phase, phase);
                check_field("failed", want.failed, failed);
                check_field("sweep_direction", want.direction, sweep_direction);
                check_field("current_offset", want.offset, current_offset);
                check_field("saved_trim_word", want.saved_word, saved_trim_word);
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((step_valid && step_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        regs = '0;
        seq_phase = PH_WAIT;
        seq_step = STEP_DAC;
        seq_dir = 1'b0;
        seq_offset = 4'd0;
        seq_retest = RT_NONE;
        seq_dac = '0;
        seq_fail = 1'b0;
        seq_saved = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_register_extremes();
        test_startup_steps();
        test_first_sweep();
        test_random_steps(RANDOM_STEPS);
        test_trim_readback();
        settle_idle();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
